// File: src/mlsq_pkg.sv
// Package: shared types and codes of the multi-list stack/queue engine.
`default_nettype none
package mlsq_pkg;
    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_PUSH   = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_LIST = 3'd1,
        ST_EXISTS  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture command word
        logic commit;  // apply updates and register result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy_unused;
    } dp_stat_t;
endpackage
`default_nettype wire

// File: src/mlsq_if.sv
// Interfaces: valid/ready channels for command and result words.
`default_nettype none
interface mlsq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  list_id;
    logic        make_stack;
    logic [31:0] push_value;
    modport source (output valid, opcode, list_id, make_stack, push_value, input ready);
    modport sink (input valid, opcode, list_id, make_stack, push_value, output ready);
endinterface

interface mlsq_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] pop_value;
    modport source (output valid, status, pop_value, input ready);
    modport sink (input valid, status, pop_value, output ready);
endinterface
`default_nettype wire

// File: src/multi_list_stack_queue_engine_unit.sv
// Top level: multi-list stack/queue engine.
// Each command reads the list table and node memories at the edge that takes its word,
// writes links back in the next cycle and registers its result together with them; the
// block takes no new word until that result is taken, as the link memory is read then written.
// Result is held until taken.
`default_nettype none
module multi_list_stack_queue_engine_unit #(
    parameter int LISTS      = 16,
    parameter int NODES      = 256,
    parameter int DATA_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    mlsq_cmd_if.sink   cmd,
    mlsq_res_if.source res
);
    mlsq_pkg::dp_cmd_t  dcmd;
    mlsq_pkg::dp_stat_t dstat;

    mlsq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(cmd.valid), .in_ready(cmd.ready),
        .out_valid(res.valid), .out_ready(res.ready),
        .stat(dstat), .cmd(dcmd)
    );

    mlsq_dp #(.LISTS(LISTS), .NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dcmd), .stat(dstat),
        .opcode(cmd.opcode), .list_id(cmd.list_id), .make_stack(cmd.make_stack),
        .push_value(cmd.push_value), .status(res.status), .pop_value(res.pop_value)
    );
endmodule
`default_nettype wire

// File: src/mlsq_ctrl.sv
// Controller: sequences capture, execute and result hand-off.
`default_nettype none
module mlsq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire mlsq_pkg::dp_stat_t stat,
    output mlsq_pkg::dp_cmd_t      cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;
    state_t state_reg;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign cmd.load   = in_valid && in_ready;
    assign cmd.commit = (state_reg == S_EXEC) && !stat.busy_unused;

    // advance through capture, execute, deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_valid) state_reg <= S_EXEC;
                S_EXEC: state_reg <= S_OUT;
                S_OUT:  if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EXEC) else $error("load not followed by exec");
    a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid) else $error("commit not followed by result");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
endmodule
`default_nettype wire

// File: src/mlsq_dp.sv
// Datapath: list table, node memories, free list and result register.
`default_nettype none
module mlsq_dp #(
    parameter int LISTS      = 16,
    parameter int NODES      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mlsq_pkg::dp_cmd_t cmd,
    output mlsq_pkg::dp_stat_t     stat,
    input  wire logic [1:0]        opcode,
    input  wire logic [3:0]        list_id,
    input  wire logic              make_stack,
    input  wire logic [31:0]       push_value,
    output logic [2:0]             status,
    output logic [31:0]            pop_value
);
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;

    // list table (small, flops)
    logic [LISTS-1:0] in_use_reg, is_stack_reg;
    logic [CW-1:0]    count_reg [LISTS];
    logic [NW-1:0]    head_reg  [LISTS];
    logic [NW-1:0]    tail_reg  [LISTS];
    // node memories
    logic [DATA_WIDTH-1:0] value_mem [NODES];
    logic [NW-1:0]         link_mem  [NODES];
    logic [NW-1:0] free_head_reg;
    logic [CW-1:0] free_count_reg, fresh_reg;

    // captured command
    logic [1:0]            op_reg;
    logic [3:0]            id_reg;
    logic                  stk_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] hval_reg;
    logic [NW-1:0]         hlink_reg, flink_reg;

    assign stat.busy_unused = 1'b0;

    logic          id_ok;
    logic [LW-1:0] l;
    assign id_ok = (32'(id_reg) < 32'(LISTS));
    assign l     = LW'(id_reg);

    // capture command and read node memories at the head and free head
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            id_reg    <= list_id;
            stk_reg   <= make_stack;
            word_reg  <= DATA_WIDTH'(push_value);
            hval_reg  <= value_mem[head_reg[LW'(list_id)]];
            hlink_reg <= link_mem[head_reg[LW'(list_id)]];
            flink_reg <= link_mem[free_head_reg];
        end
    end

    logic          in_use, have_free, have_fresh;
    logic [NW-1:0] n, h;
    logic [2:0]    st;
    logic          do_create, do_push, do_pop;
    always_comb
    begin
        in_use     = id_ok && in_use_reg[l];
        have_free  = (free_count_reg != '0);
        have_fresh = (fresh_reg < CW'(NODES));
        n          = have_free ? free_head_reg : NW'(fresh_reg);
        h          = head_reg[l];
        st         = mlsq_pkg::ST_OK;
        do_create  = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        unique case (mlsq_pkg::op_t'(op_reg))
            mlsq_pkg::OP_CREATE:
                priority if (!id_ok) st = mlsq_pkg::ST_NO_LIST;
                else if (in_use_reg[l]) st = mlsq_pkg::ST_EXISTS;
                else do_create = 1'b1;
            mlsq_pkg::OP_PUSH:
                priority if (!in_use) st = mlsq_pkg::ST_NO_LIST;
                else if (!have_free && !have_fresh) st = mlsq_pkg::ST_FULL;
                else do_push = 1'b1;
            mlsq_pkg::OP_POP:
                priority if (!in_use) st = mlsq_pkg::ST_NO_LIST;
                else if (count_reg[l] == '0) st = mlsq_pkg::ST_EMPTY;
                else do_pop = 1'b1;
            default: st = mlsq_pkg::ST_OK;
        endcase
    end

    // pick the single link write: pop recycles the head, stack push links the new
    // node to the head, queue push links the old tail to the new node
    logic          link_we;
    logic [NW-1:0] link_addr, link_data;
    always_comb
    begin
        link_we   = do_pop || (do_push && count_reg[l] != '0);
        link_addr = do_pop ? h : (is_stack_reg[l] ? n : tail_reg[l]);
        link_data = do_pop ? free_head_reg : (is_stack_reg[l] ? h : n);
    end

    // node memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_push)
        begin
            value_mem[n] <= word_reg;
        end
        if (cmd.commit && link_we)
        begin
            link_mem[link_addr] <= link_data;
        end
    end

    // list heads, tails, result
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status    <= st;
            pop_value <= do_pop ? 32'(hval_reg) : '0;
            if (do_push)
            begin
                if (count_reg[l] == '0)
                begin
                    head_reg[l] <= n;
                    tail_reg[l] <= n;
                end
                else if (is_stack_reg[l]) head_reg[l] <= n;
                else tail_reg[l] <= n;
            end
            if (do_pop) head_reg[l] <= hlink_reg;
        end
    end

    // control state: flags, counts, free list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg     <= '0;
            is_stack_reg   <= '0;
            for (int i = 0; i < LISTS; i++) count_reg[i] <= '0;
            free_head_reg  <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            if (do_create)
            begin
                in_use_reg[l]   <= 1'b1;
                is_stack_reg[l] <= stk_reg;
                count_reg[l]    <= '0;
            end
            if (do_push)
            begin
                count_reg[l] <= count_reg[l] + CW'(1);
                if (have_free)
                begin
                    free_head_reg  <= flink_reg;
                    free_count_reg <= free_count_reg - CW'(1);
                end
                else fresh_reg <= fresh_reg + CW'(1);
            end
            if (do_pop)
            begin
                count_reg[l]   <= count_reg[l] - CW'(1);
                free_head_reg  <= h;
                free_count_reg <= free_count_reg + CW'(1);
            end
        end
    end

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= fresh_reg) else $error("free count exceeds allocated nodes");
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CW'(NODES)) else $error("fresh pointer beyond pool");
    a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && do_pop) |-> count_reg[l] != '0) else $error("pop on empty list");
endmodule
`default_nettype wire

// File: tb/multi_list_stack_queue_engine_unit_tb.sv
// Testbench: command and result checking of the multi-list stack/queue engine.
`default_nettype none
module multi_list_stack_queue_engine_unit_tb;
    localparam int LISTS = 16;
    localparam int NODES = 256;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        mlsq_pkg::status_t status;
        logic [31:0]       pop_value;
    } result_word_t;

    logic clk;
    logic rst_n;
    mlsq_cmd_if cmd ();
    mlsq_res_if res ();

    multi_list_stack_queue_engine_unit #(
        .LISTS(LISTS),
        .NODES(NODES),
        .DATA_WIDTH(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd.sink),
        .res(res.source)
    );

    // shadow state of the engine
    logic        shadow_in_use [LISTS];
    logic        shadow_is_stack [LISTS];
    logic [7:0]  shadow_head [LISTS];
    logic [7:0]  shadow_tail [LISTS];
    int          shadow_count [LISTS];
    logic [31:0] shadow_value [NODES];
    logic [7:0]  shadow_link [NODES];
    logic [7:0]  shadow_free_head;
    int          shadow_free_count;
    int          shadow_fresh_next;

    result_word_t expected_results[$];
    int           error_count;
    int           words_sent;
    int           words_checked;
    int           cycle_count;
    bit           hold_off;
    int           hold_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // timeout
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("%0t timeout, %0d results still expected", $time,
                    expected_results.size());
                $display("multi_list_stack_queue_engine_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // compute expected result of one command and advance the shadow state
    function automatic result_word_t predict_command(mlsq_pkg::op_t op, logic [3:0] id,
                                                     logic stack_mode, logic [31:0] word);
        result_word_t r;
        logic [7:0]   n;
        logic [7:0]   h;
        r.status = mlsq_pkg::ST_OK;
        r.pop_value = '0;
        case (op)
            mlsq_pkg::OP_CREATE:
            begin
                if (shadow_in_use[id])
                    r.status = mlsq_pkg::ST_EXISTS;
                else
                begin
                    shadow_in_use[id] = 1'b1;
                    shadow_is_stack[id] = stack_mode;
                    shadow_count[id] = 0;
                end
            end
            mlsq_pkg::OP_PUSH:
            begin
                if (!shadow_in_use[id])
                    r.status = mlsq_pkg::ST_NO_LIST;
                else if (shadow_free_count == 0 && shadow_fresh_next >= NODES)
                    r.status = mlsq_pkg::ST_FULL;
                else
                begin
                    // reuse the most recently freed node first
                    if (shadow_free_count > 0)
                    begin
                        n = shadow_free_head;
                        shadow_free_head = shadow_link[n];
                        shadow_free_count--;
                    end
                    else
                    begin
                        n = shadow_fresh_next[7:0];
                        shadow_fresh_next++;
                    end
                    shadow_value[n] = word;
                    if (shadow_count[id] == 0)
                    begin
                        shadow_link[n] = '0;
                        shadow_head[id] = n;
                        shadow_tail[id] = n;
                    end
                    else if (shadow_is_stack[id])
                    begin
                        shadow_link[n] = shadow_head[id];
                        shadow_head[id] = n;
                    end
                    else
                    begin
                        shadow_link[n] = '0;
                        shadow_link[shadow_tail[id]] = n;
                        shadow_tail[id] = n;
                    end
                    shadow_count[id]++;
                end
            end
            mlsq_pkg::OP_POP:
            begin
                if (!shadow_in_use[id])
                    r.status = mlsq_pkg::ST_NO_LIST;
                else if (shadow_count[id] == 0)
                    r.status = mlsq_pkg::ST_EMPTY;
                else
                begin
                    h = shadow_head[id];
                    r.pop_value = shadow_value[h];
                    shadow_head[id] = shadow_link[h];
                    shadow_count[id]--;
                    if (shadow_count[id] == 0)
                    begin
                        shadow_head[id] = '0;
                        shadow_tail[id] = '0;
                    end
                    shadow_link[h] = (shadow_free_count > 0) ? shadow_free_head : 8'd0;
                    shadow_free_head = h;
                    shadow_free_count++;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // send one command word after a random gap, then queue its expected result
    task automatic send_command(mlsq_pkg::op_t op, logic [3:0] id, logic stack_mode,
                                logic [31:0] word, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        if ($urandom_range(0, 7) < 3)
            gap = 0;
        // step off the edge that took the previous word
        @(posedge clk);
        repeat (gap) @(posedge clk);
        cmd.valid <= 1'b1;
        cmd.opcode <= op;
        cmd.list_id <= id;
        cmd.make_stack <= stack_mode;
        cmd.push_value <= word;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        expected_results.push_back(predict_command(op, id, stack_mode, word));
        words_sent++;
        cmd.valid <= 1'b0;
    endtask

    // wait until every expected result has come
    task automatic drain_results();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // receiver: random stalls, long hold-off on request
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                res.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_off = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // compare each accepted result word with the oldest expectation
    initial
    begin
        result_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result: status %0d value %h", $time,
                        res.status, res.pop_value);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    words_checked++;
                    if (res.status !== want.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d", $time,
                            want.status, res.status);
                        error_count++;
                    end
                    if (res.pop_value !== want.pop_value)
                    begin
                        $display("%0t pop_value mismatch: expected %h actual %h", $time,
                            want.pop_value, res.pop_value);
                        error_count++;
                    end
                end
            end
        end
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // create both kinds, duplicates, empty and unknown cases, unused opcode
    task automatic test_directed();
        send_command(mlsq_pkg::OP_POP, 4'd0, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_PUSH, 4'd15, 1'b0, 32'hFFFF_FFFF);
        send_command(mlsq_pkg::OP_CREATE, 4'd0, 1'b1, 32'h0);
        send_command(mlsq_pkg::OP_CREATE, 4'd15, 1'b0, 32'hFFFF_FFFF);
        send_command(mlsq_pkg::OP_CREATE, 4'd0, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_POP, 4'd15, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_PUSH, 4'd0, 1'b0, 32'h0000_0001);
        send_command(mlsq_pkg::OP_PUSH, 4'd0, 1'b1, 32'hFFFF_FFFF);
        send_command(mlsq_pkg::OP_PUSH, 4'd15, 1'b1, 32'hA5A5_5A5A);
        send_command(mlsq_pkg::OP_PUSH, 4'd15, 1'b0, 32'h0000_0000);
        send_command(mlsq_pkg::OP_POP, 4'd0, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_POP, 4'd0, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_POP, 4'd0, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_POP, 4'd15, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_NONE, 4'd7, 1'b1, 32'h1234_5678);
        send_command(mlsq_pkg::OP_POP, 4'd15, 1'b0, 32'h0);
        send_command(mlsq_pkg::OP_POP, 4'd15, 1'b0, 32'h0);
    endtask

    // fill the pool, hit pool full, pop part of it back and recycle the freed nodes
    task automatic test_pool_exhaust();
        send_command(mlsq_pkg::OP_CREATE, 4'd1, 1'b0, 32'h0);
        for (int i = 0; i < NODES + 3; i++)
            send_command(mlsq_pkg::OP_PUSH, (i % 2) ? 4'd1 : 4'd0, 1'b0, $urandom(), 1'b1);
        for (int i = 0; i < 6; i++)
            send_command(mlsq_pkg::OP_POP, 4'd0, 1'b0, 32'h0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_command(mlsq_pkg::OP_PUSH, 4'd15, 1'b0, $urandom(), 1'b1);
        for (int i = 0; i < NODES + 8; i++)
            send_command(mlsq_pkg::OP_POP, 4'(i % 3 == 0 ? 15 : i % 3), 1'b0, 32'h0, 1'b1);
        drain_results();
    endtask

    // receiver holds off while commands keep coming, so the block backs up
    task automatic test_backpressure();
        hold_cycles = 300;
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++)
            send_command(mlsq_pkg::OP_PUSH, 4'd1, 1'b0, $urandom(), 1'b1);
        drain_results();
    endtask

    // mostly pushes and pops on random lists, some creates and unused opcodes
    task automatic test_random(int count);
        logic [3:0]    id;
        mlsq_pkg::op_t op;
        for (int i = 0; i < count; i++)
        begin
            id = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 4)
                op = mlsq_pkg::OP_CREATE;
            else if ($urandom_range(0, 99) < 2)
                op = mlsq_pkg::OP_NONE;
            else
                op = ($urandom_range(0, 99) < ((i / 200) % 2 ? 40 : 60)) ?
                    mlsq_pkg::OP_PUSH : mlsq_pkg::OP_POP;
            send_command(op, id, 1'($urandom_range(0, 1)), random_word());
        end
    endtask

    initial
    begin
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        hold_off = 1'b0;
        hold_cycles = 0;
        for (int i = 0; i < LISTS; i++)
        begin
            shadow_in_use[i] = 1'b0;
            shadow_is_stack[i] = 1'b0;
            shadow_head[i] = '0;
            shadow_tail[i] = '0;
            shadow_count[i] = 0;
        end
        shadow_free_head = '0;
        shadow_free_count = 0;
        shadow_fresh_next = 0;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.opcode = mlsq_pkg::OP_NONE;
        cmd.list_id = '0;
        cmd.make_stack = 1'b0;
        cmd.push_value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pool_exhaust();
        test_backpressure();
        test_random(1365);

        drain_results();
        $display("Sent %0d commands, checked %0d results, incl. pool full and backpressure.",
            words_sent, words_checked);
        if (error_count == 0)
            $display("multi_list_stack_queue_engine_unit_tb: done, clean");
        else
            $display("multi_list_stack_queue_engine_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
src/mlsq_pkg.sv
src/mlsq_if.sv
src/mlsq_ctrl.sv
src/mlsq_dp.sv
src/multi_list_stack_queue_engine_unit.sv
tb/multi_list_stack_queue_engine_unit_tb.sv
